### sv/clbp_pkg.sv
// ----------------------------------------------------------------------------
// clbp_pkg
// Shared types, widths and build-time geometry helpers for the circular
// LBP code stream: item structs, register indexes and the circle point math.
// ----------------------------------------------------------------------------
package clbp_pkg;

  localparam int PIX_W      = 8;
  localparam int CODE_W     = 8;
  localparam int FW_W       = 11;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int FRAC_W     = 12;
  localparam int WGT_W      = FRAC_W + 1;
  localparam int PROD_W     = PIX_W + WGT_W;
  localparam int SUM_W      = PROD_W + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 12'd480;

  localparam longint ONE_Q30    = 64'sd1073741824;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint HALF_Q12   = 64'sd131072;
  localparam longint ONE_Q12    = 64'sd4096;
  localparam longint FRAC_MASK  = 64'sd4095;
  localparam longint HALF_LSB   = 64'sd2048;

  localparam longint SIN_DIV [1:9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};
  localparam longint COS_DIV [1:9] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] pattern_code;
    logic              last_code;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] cx;
    logic signed [31:0] fy;
    logic signed [31:0] cy;
    logic signed [31:0] w0;
    logic signed [31:0] w1;
    logic signed [31:0] w2;
    logic signed [31:0] w3;
  } geom_t;

  function automatic longint sin_series(longint phi);
    longint phi2;
    longint s;
    longint t;
    phi2 = phi * phi / ONE_Q30;
    s = phi;
    t = phi;
    for (int k = 1; k <= 9; k++) begin
      t = t * phi2 / ONE_Q30;
      t = -(t / SIN_DIV[k]);
      s = s + t;
    end
    return s;
  endfunction

  function automatic longint cos_series(longint phi);
    longint phi2;
    longint c;
    longint t;
    phi2 = phi * phi / ONE_Q30;
    c = ONE_Q30;
    t = ONE_Q30;
    for (int k = 1; k <= 9; k++) begin
      t = t * phi2 / ONE_Q30;
      t = -(t / COS_DIV[k]);
      c = c + t;
    end
    return c;
  endfunction

  function automatic longint circle_x(longint phi, longint q);
    longint r;
    logic [1:0] quad;
    quad = q[1:0];
    case (quad)
      2'd0:    r = cos_series(phi);
      2'd1:    r = -sin_series(phi);
      2'd2:    r = -cos_series(phi);
      default: r = sin_series(phi);
    endcase
    return r;
  endfunction

  function automatic longint circle_y(longint phi, longint q);
    longint r;
    logic [1:0] quad;
    quad = q[1:0];
    case (quad)
      2'd0:    r = sin_series(phi);
      2'd1:    r = cos_series(phi);
      2'd2:    r = -sin_series(phi);
      default: r = -cos_series(phi);
    endcase
    return r;
  endfunction

  function automatic geom_t point_geom(longint phi, longint q, longint radius);
    longint x12;
    longint y12;
    longint fx;
    longint fy;
    longint tx;
    longint ty;
    geom_t  g;
    x12 = ((radius * circle_x(phi, q)) + HALF_Q12) >>> 18;
    y12 = ((-(radius * circle_y(phi, q))) + HALF_Q12) >>> 18;
    fx = x12 >>> FRAC_W;
    fy = y12 >>> FRAC_W;
    tx = x12 & FRAC_MASK;
    ty = y12 & FRAC_MASK;
    g.fx = 32'(fx);
    g.fy = 32'(fy);
    g.cx = (tx == 0) ? 32'(fx) : 32'(fx + 1);
    g.cy = (ty == 0) ? 32'(fy) : 32'(fy + 1);
    g.w0 = 32'((((ONE_Q12 - tx) * (ONE_Q12 - ty)) + HALF_LSB) >>> FRAC_W);
    g.w1 = 32'(((tx * (ONE_Q12 - ty)) + HALF_LSB) >>> FRAC_W);
    g.w2 = 32'((((ONE_Q12 - tx) * ty) + HALF_LSB) >>> FRAC_W);
    g.w3 = 32'(((tx * ty) + HALF_LSB) >>> FRAC_W);
    return g;
  endfunction

endpackage

### sv/circular_lbp_code_stream_top.sv
// ----------------------------------------------------------------------------
// circular_lbp_code_stream_top
// Path: line RAM read and stage 1, window cells in stage 2, point products in stage 3, output register in stage 4.
// Throughput: one pixel per clock unless out_stall backs up the pipe; set by the line RAM read and window shift.
// Reset: position counters clear, frame_width 640, frame_height 480.
// Line RAMs are not cleared; border pixels give no code.
// ----------------------------------------------------------------------------
module circular_lbp_code_stream_top #(
  parameter int RADIUS    = 1,
  parameter int NEIGHBORS = 8,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  clbp_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output clbp_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [clbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [clbp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SIDE   = 2 * RADIUS + 1;
  localparam int NB_EFF = (NEIGHBORS > 31) ? 31 : ((NEIGHBORS < 1) ? 1 : NEIGHBORS);
  localparam int NB_OUT = (NB_EFF < clbp_pkg::CODE_W) ? NB_EFF : clbp_pkg::CODE_W;
  localparam int SEL_W  = $clog2(SIDE);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = ($clog2(MAX_WIDTH + 1) > clbp_pkg::FW_W) ?
                          $clog2(MAX_WIDTH + 1) : clbp_pkg::FW_W;
  localparam int ROW_W  = clbp_pkg::ROW_W;
  localparam int PIX_W  = clbp_pkg::PIX_W;

  // configuration
  logic [clbp_pkg::FW_W-1:0] cfg_width_r;
  logic [ROW_W-1:0]          cfg_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= clbp_pkg::WIDTH_RESET;
      cfg_height_r <= clbp_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clbp_pkg::CFG_FRAME_WIDTH:  cfg_width_r  <= cfg_data[clbp_pkg::FW_W-1:0];
        clbp_pkg::CFG_FRAME_HEIGHT: cfg_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WID_W-1:0] fw_ext;
  logic [WID_W-1:0] width_eff;
  logic [ROW_W-1:0] height_eff;

  assign fw_ext = WID_W'(cfg_width_r);
  assign width_eff = (fw_ext > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) :
                     ((fw_ext == '0) ? WID_W'(1) : fw_ext);
  assign height_eff = (cfg_height_r == '0) ? ROW_W'(1) : cfg_height_r;

  // stage enables
  logic out_valid_r;
  logic s1_v_r, s2_v_r, s3_v_r;
  logic e1, e2, e3, e4;
  logic accept;

  assign e4 = !out_valid_r || !out_stall;
  assign e3 = !s3_v_r || e4;
  assign e2 = !s2_v_r || e3;
  assign e1 = !s1_v_r || e2;
  assign in_stall = !e1;
  assign accept = in_valid && e1;

  // position counters
  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;
  logic [SEL_W-1:0] sel_r, sel_nxt, sel_cur;
  logic [WID_W-1:0] col_inc;
  logic [ROW_W:0]   row_inc;
  logic             col_wrap;
  logic             emit;
  logic             last;

  assign col_cur = in_item.frame_start ? '0 : col_r;
  assign row_cur = in_item.frame_start ? '0 : row_r;
  assign sel_cur = in_item.frame_start ? '0 : sel_r;
  assign col_inc = WID_W'(col_cur) + WID_W'(1);
  assign row_inc = (ROW_W + 1)'(row_cur) + (ROW_W + 1)'(1);
  assign col_wrap = col_inc >= width_eff;

  always_comb begin
    col_nxt = col_inc[COL_W-1:0];
    row_nxt = row_cur;
    sel_nxt = sel_cur;
    if (col_wrap) begin
      col_nxt = '0;
      if (row_inc >= (ROW_W + 1)'(height_eff)) begin
        row_nxt = '0;
        sel_nxt = '0;
      end else begin
        row_nxt = row_inc[ROW_W-1:0];
        sel_nxt = (sel_cur == SEL_W'(SIDE - 1)) ? '0 : sel_cur + SEL_W'(1);
      end
    end else if (row_cur >= height_eff) begin
      row_nxt = '0;
      sel_nxt = '0;
    end
  end

  assign emit = (row_cur >= ROW_W'(2 * RADIUS)) && (col_cur >= COL_W'(2 * RADIUS));
  assign last = (row_cur == height_eff - ROW_W'(1)) &&
                (WID_W'(col_cur) == width_eff - WID_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      sel_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      sel_r <= sel_nxt;
    end
  end

  // line RAMs, one per window row of the ring
  logic [PIX_W-1:0] ram_q [SIDE];

  for (genvar i = 0; i < SIDE; i++) begin : g_line
    clbp_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk       (clk),
      .wr_en     (accept && (sel_cur == SEL_W'(i))),
      .wr_addr   (col_cur),
      .wr_data   (in_item.pixel_value),
      .rd_en     (e1),
      .rd_addr   (col_cur),
      .rd_data_r (ram_q[i])
    );
  end

  // stage 1
  logic [PIX_W-1:0] s1_pix_r;
  logic [SEL_W-1:0] s1_sel_r;
  logic             s1_emit_r;
  logic             s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (e1) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_item.pixel_value;
      s1_sel_r  <= sel_cur;
      s1_emit_r <= emit;
      s1_last_r <= last;
    end
  end

  // new window column: oldest line on top, current pixel at the bottom
  logic [SIDE-1:0][PIX_W-1:0] col_new;

  for (genvar a = 0; a < SIDE - 1; a++) begin : g_colsel
    logic [SEL_W:0]   idx_sum;
    logic [SEL_W-1:0] idx;
    assign idx_sum = (SEL_W + 1)'(s1_sel_r) + (SEL_W + 1)'(a + 1);
    assign idx = (idx_sum >= (SEL_W + 1)'(SIDE)) ?
                 SEL_W'(idx_sum - (SEL_W + 1)'(SIDE)) : idx_sum[SEL_W-1:0];
    assign col_new[a] = ram_q[idx];
  end
  assign col_new[SIDE-1] = s1_pix_r;

  // stage 2: window as a chain of column cells
  logic                       shift_en;
  logic [SIDE-1:0][PIX_W-1:0] cell_q [SIDE];
  logic [PIX_W-1:0]           win [SIDE][SIDE];
  logic                       s2_last_r;

  assign shift_en = e2 && s1_v_r;

  for (genvar b = 0; b < SIDE; b++) begin : g_cell
    clbp_col_cell #(
      .SIDE (SIDE)
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .col_in   ((b == SIDE - 1) ? col_new : cell_q[(b == SIDE - 1) ? b : b + 1]),
      .col_r    (cell_q[b])
    );
    for (genvar a = 0; a < SIDE; a++) begin : g_row
      assign win[a][b] = cell_q[b][a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (e2) begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e2) begin
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: registered products inside each point, centre alongside
  logic [PIX_W-1:0]  centre_r;
  logic              s3_last_r;
  logic [NB_OUT-1:0] gt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (e3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e3) begin
      centre_r  <= win[RADIUS][RADIUS];
      s3_last_r <= s2_last_r;
    end
  end

  for (genvar n = 0; n < NB_OUT; n++) begin : g_pt
    localparam longint Q   = (8 * longint'(n) + longint'(NB_EFF)) / (2 * longint'(NB_EFF));
    localparam longint PHI = clbp_pkg::TWO_PI_Q30 * (4 * longint'(n) - Q * longint'(NB_EFF))
                             / (4 * longint'(NB_EFF));
    localparam clbp_pkg::geom_t G = clbp_pkg::point_geom(PHI, Q, longint'(RADIUS));
    localparam int FX = int'(G.fx) + RADIUS;
    localparam int CX = int'(G.cx) + RADIUS;
    localparam int FY = int'(G.fy) + RADIUS;
    localparam int CY = int'(G.cy) + RADIUS;

    clbp_point #(
      .W0 (int'(G.w0)),
      .W1 (int'(G.w1)),
      .W2 (int'(G.w2)),
      .W3 (int'(G.w3))
    ) u_pt (
      .clk       (clk),
      .en        (e3),
      .pix_in    ({win[CY][CX], win[CY][FX], win[FY][CX], win[FY][FX]}),
      .centre_in (centre_r),
      .gt        (gt[n])
    );
  end

  // stage 4: output register
  logic [clbp_pkg::CODE_W-1:0] code_nxt;
  clbp_pkg::out_item_t         out_item_r;

  always_comb begin
    code_nxt = '0;
    for (int n = 0; n < NB_OUT; n++) begin
      code_nxt[n] = gt[n];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (e4) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e4 && s3_v_r) begin
      out_item_r.pattern_code <= code_nxt;
      out_item_r.last_code    <= s3_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### sv/clbp_ram.sv
// ----------------------------------------------------------------------------
// clbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

### sv/clbp_col_cell.sv
// ----------------------------------------------------------------------------
// clbp_col_cell
// One column of the pixel window; takes the column of its right-hand
// neighbor whenever the window advances.
// ----------------------------------------------------------------------------
module clbp_col_cell #(
  parameter int SIDE = 3
) (
  input  logic                                  clk,
  input  logic                                  shift_en,
  input  logic [SIDE-1:0][clbp_pkg::PIX_W-1:0]  col_in,
  output logic [SIDE-1:0][clbp_pkg::PIX_W-1:0]  col_r
);

  logic [SIDE-1:0][clbp_pkg::PIX_W-1:0] col_nxt;

  assign col_nxt = shift_en ? col_in : col_r;

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end

endmodule

### sv/clbp_point.sv
// ----------------------------------------------------------------------------
// clbp_point
// One circle point: constant-weight bilinear blend of four window pixels,
// compared against the scaled centre pixel.
// ----------------------------------------------------------------------------
module clbp_point #(
  parameter int unsigned W0 = 4096,
  parameter int unsigned W1 = 0,
  parameter int unsigned W2 = 0,
  parameter int unsigned W3 = 0
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [3:0][clbp_pkg::PIX_W-1:0]    pix_in,
  input  logic [clbp_pkg::PIX_W-1:0]         centre_in,
  output logic                               gt
);

  localparam logic [clbp_pkg::WGT_W-1:0] WGT [4] = '{
    clbp_pkg::WGT_W'(W0), clbp_pkg::WGT_W'(W1),
    clbp_pkg::WGT_W'(W2), clbp_pkg::WGT_W'(W3)
  };

  logic [clbp_pkg::PROD_W-1:0] prod_r   [4];
  logic [clbp_pkg::PROD_W-1:0] prod_nxt [4];
  logic [clbp_pkg::SUM_W-1:0]  blend;
  logic [clbp_pkg::SUM_W-1:0]  ref_level;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_nxt[i] = clbp_pkg::PROD_W'(pix_in[i]) * clbp_pkg::PROD_W'(WGT[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign blend = clbp_pkg::SUM_W'(prod_r[0]) + clbp_pkg::SUM_W'(prod_r[1])
               + clbp_pkg::SUM_W'(prod_r[2]) + clbp_pkg::SUM_W'(prod_r[3]);
  assign ref_level = clbp_pkg::SUM_W'({centre_in, {clbp_pkg::FRAC_W{1'b0}}});
  assign gt = blend > ref_level;

endmodule

### tb/circular_lbp_code_stream_top_tb.sv
// ----------------------------------------------------------------------------
// circular_lbp_code_stream_top_tb
// Streams pixel frames of many geometries through the circular LBP block with
// random idle gaps on both channels. A scoreboard keeps its own line buffers
// and circle-point weights, predicts every interior code and checks each one.
// ----------------------------------------------------------------------------
module circular_lbp_code_stream_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAD   = 1;
  localparam int NBR   = 8;
  localparam int MAX_W = 1024;
  localparam int SIDE  = 2 * RAD + 1;

  localparam longint Q30_UNIT = 64'sd1073741824;
  localparam longint TAU_Q30  = 64'sd6746518852;

  class lbp_scoreboard;
    logic [clbp_pkg::PIX_W-1:0] lines [0:SIDE-1][0:MAX_W-1];
    int                         row_pos;
    int                         col_pos;
    int                         width_reg;
    int                         height_reg;
    int                         pfx [NBR];
    int                         pfy [NBR];
    int                         pcx [NBR];
    int                         pcy [NBR];
    longint                     pw [NBR][4];
    clbp_pkg::out_item_t        codes_due [$];
    int                         mismatches;

    function new();
      foreach (lines[a, b]) lines[a][b] = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = 640;
      height_reg = 480;
      mismatches = 0;
      build_circle();
    endfunction

    function longint fdiv(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
    endfunction

    function void build_circle();
      longint q, phi, phi2, s, c, t, cv, sv, x12, y12, fx, fy, tx, ty;
      for (int n = 0; n < NBR; n++) begin
        q    = (8 * n + NBR) / (2 * NBR);
        phi  = TAU_Q30 * (4 * n - q * NBR) / (4 * NBR);
        phi2 = phi * phi / Q30_UNIT;
        s = phi;
        t = phi;
        for (int k = 1; k <= 9; k++) begin
          t = t * phi2 / Q30_UNIT;
          t = -(t / ((2 * k) * (2 * k + 1)));
          s += t;
        end
        c = Q30_UNIT;
        t = Q30_UNIT;
        for (int k = 1; k <= 9; k++) begin
          t = t * phi2 / Q30_UNIT;
          t = -(t / ((2 * k - 1) * (2 * k)));
          c += t;
        end
        case (q % 4)
          0: begin cv = c;  sv = s;  end
          1: begin cv = -s; sv = c;  end
          2: begin cv = -c; sv = -s; end
          default: begin cv = s; sv = -c; end
        endcase
        x12 = fdiv(RAD * cv + 64'sd131072, 64'sd262144);
        y12 = fdiv(-(RAD * sv) + 64'sd131072, 64'sd262144);
        fx = fdiv(x12, 4096);
        fy = fdiv(y12, 4096);
        tx = x12 - fx * 4096;
        ty = y12 - fy * 4096;
        pfx[n] = int'(fx);
        pfy[n] = int'(fy);
        pcx[n] = (tx == 0) ? int'(fx) : int'(fx + 1);
        pcy[n] = (ty == 0) ? int'(fy) : int'(fy + 1);
        pw[n][0] = ((4096 - tx) * (4096 - ty) + 2048) >>> 12;
        pw[n][1] = (tx * (4096 - ty) + 2048) >>> 12;
        pw[n][2] = ((4096 - tx) * ty + 2048) >>> 12;
        pw[n][3] = (tx * ty + 2048) >>> 12;
      end
    endfunction

    function longint tap(int dy, int dx);
      return longint'(lines[(row_pos - RAD + dy) % SIDE][col_pos - RAD + dx]);
    endfunction

    function void write_reg(logic [clbp_pkg::CFG_IDX_W-1:0]  idx,
                            logic [clbp_pkg::CFG_DATA_W-1:0] data);
      if (idx == clbp_pkg::CFG_FRAME_WIDTH) begin
        width_reg = int'(data[clbp_pkg::FW_W-1:0]);
      end else if (idx == clbp_pkg::CFG_FRAME_HEIGHT) begin
        height_reg = int'(data[clbp_pkg::ROW_W-1:0]);
      end
    endfunction

    function void note_pixel(clbp_pkg::in_item_t it);
      int                  wd;
      int                  ht;
      int                  code;
      longint              ctr;
      longint              blend;
      clbp_pkg::out_item_t r;
      wd = (width_reg > MAX_W) ? MAX_W : width_reg;
      if (wd < 1) wd = 1;
      ht = (height_reg < 1) ? 1 : height_reg;
      if (it.frame_start) begin
        row_pos = 0;
        col_pos = 0;
      end
      lines[row_pos % SIDE][col_pos] = it.pixel_value;
      if (row_pos >= 2 * RAD && col_pos >= 2 * RAD) begin
        ctr  = tap(0, 0);
        code = 0;
        for (int n = 0; n < NBR; n++) begin
          blend = pw[n][0] * tap(pfy[n], pfx[n]) + pw[n][1] * tap(pfy[n], pcx[n])
                + pw[n][2] * tap(pcy[n], pfx[n]) + pw[n][3] * tap(pcy[n], pcx[n]);
          if (blend > ctr * 4096) code |= 1 << n;
        end
        r.pattern_code = code[clbp_pkg::CODE_W-1:0];
        r.last_code    = (row_pos == ht - 1 && col_pos == wd - 1);
        codes_due.push_back(r);
      end
      col_pos++;
      if (col_pos >= wd) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= ht) row_pos = 0;
      end else if (row_pos >= ht) begin
        row_pos = 0;
      end
    endfunction

    function void check_code(clbp_pkg::out_item_t got);
      clbp_pkg::out_item_t want;
      if (codes_due.size() == 0) begin
        $display("%0t: unexpected code, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = codes_due.pop_front();
      if (got.pattern_code !== want.pattern_code) begin
        $display("%0t: pattern_code expected %h actual %h", $time,
                 want.pattern_code, got.pattern_code);
        mismatches++;
      end
      if (got.last_code !== want.last_code) begin
        $display("%0t: last_code expected %b actual %b", $time,
                 want.last_code, got.last_code);
        mismatches++;
      end
    endfunction

    function int pending();
      return codes_due.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  clbp_pkg::in_item_t              in_item;
  logic                            out_valid;
  logic                            out_stall;
  clbp_pkg::out_item_t             out_item;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [clbp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [clbp_pkg::CFG_DATA_W-1:0] cfg_data;

  lbp_scoreboard              sb = new();
  bit                         no_gaps;
  bit                         hold_req;
  logic [clbp_pkg::PIX_W-1:0] prev_pix;

  circular_lbp_code_stream_top #(
    .RADIUS    (RAD),
    .NEIGHBORS (NBR),
    .MAX_WIDTH (MAX_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pixel(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_code(out_item);
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [clbp_pkg::PIX_W-1:0] next_pixel();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: prev_pix = '0;
      1: prev_pix = '1;
      2, 3: prev_pix = prev_pix;
      default: prev_pix = clbp_pkg::PIX_W'($urandom_range(0, 255));
    endcase
    return prev_pix;
  endfunction

  task automatic push_item(clbp_pkg::in_item_t v);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic stream_pixels(int count, int frame_len, bit first_mark, int noise_pm);
    clbp_pkg::in_item_t v;
    for (int i = 0; i < count; i++) begin
      if (i == 0) v.frame_start = first_mark;
      else v.frame_start = (frame_len > 0 && i % frame_len == 0)
                        || ($urandom_range(0, 999) < noise_pm);
      v.pixel_value = next_pixel();
      push_item(v);
    end
  endtask

  task automatic send_frame3(logic [clbp_pkg::PIX_W-1:0] ring,
                             logic [clbp_pkg::PIX_W-1:0] mid);
    clbp_pkg::in_item_t v;
    for (int i = 0; i < 9; i++) begin
      v.frame_start = (i == 0);
      v.pixel_value = (i == 4) ? mid : ring;
      push_item(v);
    end
  endtask

  task automatic cfg_write(logic [clbp_pkg::CFG_IDX_W-1:0] idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= clbp_pkg::CFG_DATA_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, clbp_pkg::CFG_DATA_W'(data));
  endtask

  // drain the pipe, then reprogram the frame geometry
  task automatic set_geometry(int w, int h);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write(clbp_pkg::CFG_FRAME_WIDTH, w);
    cfg_write(clbp_pkg::CFG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int g;
    int r;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        g = pick_gap();
        if (g > 0) begin
          out_stall <= 1'b1;
          repeat (g) @(posedge clk);
        end
        out_stall <= 1'b0;
        r = $urandom_range(1, 16);
        repeat (r) @(posedge clk);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int total;
    int w;
    int h;
    int frames;
    int len;
    int cnt;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_gaps   = 1'b0;
    hold_req  = 1'b0;
    prev_pix  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_geometry(3, 3);
    send_frame3('1, '0);
    send_frame3('0, '1);
    set_geometry(2, 3);
    stream_pixels(6, 6, 1'b1, 0);
    set_geometry(0, 0);
    stream_pixels(3, 3, 1'b1, 0);

    // widest line, clamped from the all-ones width
    set_geometry(12'hFFF, 3);
    stream_pixels(40, 0, 1'b1, 0);
    set_geometry(3, 12'hFFF);
    stream_pixels(240, 0, 1'b1, 0);
    // frames wrap without a start marker
    set_geometry(7, 5);
    stream_pixels(140, 0, 1'b1, 0);
    // shrink the geometry mid-frame and carry on
    set_geometry(12, 9);
    stream_pixels(50, 108, 1'b1, 0);
    set_geometry(8, 6);
    stream_pixels(150, 48, 1'b0, 0);
    // hold off the output until the input backs up
    set_geometry(16, 12);
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    stream_pixels(384, 192, 1'b1, 0);

    total = 0;
    while (total < 560) begin
      w      = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
      h      = $urandom_range(3, 8);
      frames = $urandom_range(1, 3);
      len    = w * h;
      cnt    = frames * len;
      if ($urandom_range(0, 3) == 0) cnt = cnt - $urandom_range(0, len - 1);
      no_gaps = ($urandom_range(0, 4) == 0);
      set_geometry(w, h);
      stream_pixels(cnt, len, 1'b1, ($urandom_range(0, 2) == 0) ? 15 : 0);
      total += cnt;
    end

    no_gaps = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### sim.f
sv/clbp_pkg.sv
sv/clbp_ram.sv
sv/clbp_col_cell.sv
sv/clbp_point.sv
sv/circular_lbp_code_stream_top.sv
tb/circular_lbp_code_stream_top_tb.sv
